@@ rtl/sac_pkg.sv @@
// Shared types and constants for the set-associative cache tag model.
package sac_pkg;

	localparam int MAX_SET_BITS = 6;
	localparam int WAYS         = 8;
	localparam int SETS         = 1 << MAX_SET_BITS;
	localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NW_W         = $clog2(WAYS + 1);
	localparam int ADDR_W       = 64;
	localparam int TAG_W        = 64;
	localparam int AGE_W        = 3;
	localparam int CNT_W        = 32;
	localparam int CFG_W        = 6;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_STORE  = 2'd1,
		OP_MODIFY = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		CFG_SET_BITS    = 2'd0,
		CFG_BLOCK_BITS  = 2'd1,
		CFG_WAYS_IN_USE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [ADDR_W-1:0] address;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       outcome;
		logic             second_hit;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] eviction_total;
	} result_t;

	// one memory word holds a whole set
	typedef struct packed {
		logic [WAYS-1:0]            valid;
		logic [WAYS-1:0][AGE_W-1:0] age;
		logic [WAYS-1:0][TAG_W-1:0] tag;
	} row_t;

	localparam int ROW_W = $bits(row_t);

endpackage

@@ rtl/sac_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module sac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                          wdata,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ rtl/set_assoc_cache_lru_sim.sv @@
// Set-associative cache tag model with true-LRU replacement (top level).
// Each access: start is taken when busy is low, the set row is read from the tag RAM,
// then written back in the next cycle while busy is high, so no new start is taken
// until that write-back is done; result_valid follows the write-back.
// Reset: asynchronous, clears counters, config to defaults and per-set valid flags;
// the tag RAM itself is not cleared. The receiver cannot stall results.
module set_assoc_cache_lru_sim (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  sac_pkg::cmd_t            cmd,
	output logic                     result_valid,
	output sac_pkg::result_t         result,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [sac_pkg::CFG_W-1:0] cfg_data
);

	localparam int WAYS  = sac_pkg::WAYS;
	localparam int WAY_W = sac_pkg::WAY_W;
	localparam int NW_W  = sac_pkg::NW_W;
	localparam int SET_W = sac_pkg::SET_W;
	localparam int AGE_W = sac_pkg::AGE_W;
	localparam int CNT_W = sac_pkg::CNT_W;
	localparam int TAG_W = sac_pkg::TAG_W;

	// configuration
	logic [2:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_in_use_q;

	// control
	logic busy_q;
	logic accept;

	// stage 1 (RAM read in flight)
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [1:0]       op_s1;

	logic [sac_pkg::SETS-1:0] row_used_q;
	logic [CNT_W-1:0] hit_q, miss_q, evict_q;

	// address split
	logic [2:0]       sb;
	logic [6:0]       shift;
	logic [63:0]      addr_blk;
	logic [SET_W-1:0] set_mask;
	logic [SET_W-1:0] set_in;
	logic [TAG_W-1:0] tag_in;

	// RAM
	logic [SET_W-1:0]    ram_addr;
	sac_pkg::row_t       rd_row;
	sac_pkg::row_t       wr_row;
	logic                ram_we;

	// lookup
	logic [NW_W-1:0]  nways;
	logic [WAYS-1:0]  vld;
	logic [WAYS-1:0]  in_use;
	logic             found;
	logic [WAY_W-1:0] found_way;
	logic             has_free;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] victim;
	logic [WAY_W-1:0] acc_way;
	logic [AGE_W-1:0] limit;
	logic             second;
	logic [1:0]       outcome;
	logic [CNT_W:0]   hit_sum;
	logic [CNT_W-1:0] hit_nx, miss_nx, evict_nx;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= 3'd4;
			block_bits_q  <= 6'd4;
			ways_in_use_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				sac_pkg::CFG_SET_BITS:    set_bits_q    <= cfg_data[2:0];
				sac_pkg::CFG_BLOCK_BITS:  block_bits_q  <= cfg_data;
				sac_pkg::CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// set and tag from the incoming address
	always_comb begin
		sb = (int'(set_bits_q) > sac_pkg::MAX_SET_BITS) ?
			3'(sac_pkg::MAX_SET_BITS) : set_bits_q;
		shift    = 7'(sb) + 7'(block_bits_q);
		addr_blk = cmd.address >> block_bits_q;
		set_mask = ~({SET_W{1'b1}} << sb);
		set_in   = addr_blk[SET_W-1:0] & set_mask;
		tag_in   = (shift >= 7'd64) ? '0 : (cmd.address >> shift);
	end

	assign ram_addr = busy_q ? set_s1 : set_in;

	sac_ram #(
		.WIDTH(sac_pkg::ROW_W),
		.DEPTH(sac_pkg::SETS)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wr_row),
		.rdata(rd_row)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= set_in;
			tag_s1 <= tag_in;
			op_s1  <= cmd.operation;
		end
	end

	// lookup, victim choice and age update on the row just read
	always_comb begin
		if (ways_in_use_q == 4'd0) begin
			nways = NW_W'(1);
		end else if (int'(ways_in_use_q) > WAYS) begin
			nways = NW_W'(WAYS);
		end else begin
			nways = NW_W'(ways_in_use_q);
		end

		found     = 1'b0;
		found_way = '0;
		has_free  = 1'b0;
		free_way  = '0;
		victim    = '0;
		wr_row    = rd_row;
		if (!row_used_q[set_s1]) begin
			// untouched since reset: all lines invalid, age zero
			wr_row.valid = '0;
			wr_row.age   = '0;
		end
		for (int w = 0; w < WAYS; w++) begin
			in_use[w] = (w < int'(nways));
			vld[w]    = wr_row.valid[w] && in_use[w];
			if (vld[w] && !found && wr_row.tag[w] == tag_s1) begin
				found     = 1'b1;
				found_way = WAY_W'(w);
			end
			if (in_use[w] && !wr_row.valid[w] && !has_free) begin
				has_free = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		for (int w = 1; w < WAYS; w++) begin
			if (in_use[w] && wr_row.age[w] > wr_row.age[victim]) begin
				victim = WAY_W'(w);
			end
		end

		if (found) begin
			acc_way = found_way;
			outcome = sac_pkg::OUT_HIT;
		end else if (has_free) begin
			acc_way = free_way;
			outcome = sac_pkg::OUT_FILL;
		end else begin
			acc_way = victim;
			outcome = sac_pkg::OUT_EVICT;
		end
		limit = wr_row.age[acc_way];

		for (int w = 0; w < WAYS; w++) begin
			if (vld[w] && WAY_W'(w) != acc_way &&
				(outcome == sac_pkg::OUT_FILL || wr_row.age[w] < limit) &&
				wr_row.age[w] != sac_pkg::AGE_MAX) begin
				wr_row.age[w] = wr_row.age[w] + AGE_W'(1);
			end
		end
		wr_row.age[acc_way]   = '0;
		wr_row.valid[acc_way] = 1'b1;
		if (!found) begin
			wr_row.tag[acc_way] = tag_s1;
		end

		second   = (op_s1 == sac_pkg::OP_MODIFY);
		hit_sum  = {1'b0, hit_q} + (CNT_W+1)'(found) + (CNT_W+1)'(second);
		hit_nx   = hit_sum[CNT_W] ? sac_pkg::CNT_MAX : hit_sum[CNT_W-1:0];
		miss_nx  = (!found && miss_q != sac_pkg::CNT_MAX) ? miss_q + 1'b1 : miss_q;
		evict_nx = (outcome == sac_pkg::OUT_EVICT && evict_q != sac_pkg::CNT_MAX) ?
			evict_q + 1'b1 : evict_q;
	end

	assign ram_we = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			result_valid <= 1'b0;
			row_used_q   <= '0;
			hit_q        <= '0;
			miss_q       <= '0;
			evict_q      <= '0;
		end else begin
			busy_q       <= accept;
			result_valid <= busy_q;
			if (busy_q) begin
				row_used_q[set_s1] <= 1'b1;
				hit_q              <= hit_nx;
				miss_q             <= miss_nx;
				evict_q            <= evict_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			result.outcome        <= outcome;
			result.second_hit     <= second;
			result.hit_total      <= hit_nx;
			result.miss_total     <= miss_nx;
			result.eviction_total <= evict_nx;
		end
	end

endmodule
